[rtl/svx_pkg.sv]
package svx_pkg;

	// Sizes of the architectural state.
	localparam int NUM_REGS    = 16;
	localparam int NUM_WORKERS = 8;
	localparam int PC_BITS     = 16;

	localparam int REG_AW = $clog2(NUM_REGS);
	localparam int WRK_AW = $clog2(NUM_WORKERS);

	// Field widths of the instruction and result transactions.
	localparam int OP_W      = 4;
	localparam int REG_IDX_W = 4;
	localparam int WORKER_W  = 3;
	localparam int IMM_B_W   = 16;
	localparam int DATA_W    = 64;

	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 4'd0,
		OP_ADDI = 4'd1,
		OP_BEQ  = 4'd2,
		OP_BGE  = 4'd3,
		OP_BLT  = 4'd4,
		OP_BNE  = 4'd5,
		OP_JAL  = 4'd6,
		OP_JALR = 4'd7,
		OP_STP  = 4'd8,
		OP_ADV  = 4'd9
	} op_t;

	typedef logic [PC_BITS-1:0]   pc_t;
	typedef logic [DATA_W-1:0]    data_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [WORKER_W-1:0]  worker_t;

	// Operands of one instruction, gathered after the state reads.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		worker_t            worker;
		reg_idx_t           ra;
		reg_idx_t           rb;
		logic [IMM_B_W-1:0] imm_b;
		data_t              imm_c;
		data_t              opnd_a;
		data_t              opnd_b;
		pc_t                pc;
	} exe_req_t;

	// Outcome of one instruction: state updates and result fields.
	typedef struct packed {
		pc_t      npc;
		logic     stop;
		logic     wrote;
		reg_idx_t wreg;
		data_t    wval;
		logic     pc_we;
	} exe_res_t;

	// A register index that names real storage other than the zero register.
	function automatic logic reg_writable(input reg_idx_t idx);
		return (idx != '0) && (int'(idx) < NUM_REGS);
	endfunction

endpackage

[rtl/svx_regfile.sv]
module svx_regfile (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [svx_pkg::REG_IDX_W-1:0] rd_addr0,
	input  logic [svx_pkg::REG_IDX_W-1:0] rd_addr1,
	output logic [svx_pkg::DATA_W-1:0]    rd_data0,
	output logic [svx_pkg::DATA_W-1:0]    rd_data1,
	input  logic                         wr_en,
	input  logic [svx_pkg::REG_IDX_W-1:0] wr_addr,
	input  logic [svx_pkg::DATA_W-1:0]    wr_data
);
	import svx_pkg::*;

	data_t               mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	data_t               raw0_q;
	data_t               raw1_q;
	logic                ok0_q;
	logic                ok1_q;

	// Write port; the zero register and out-of-range indexes are never written.
	always_ff @(posedge clk) begin
		if (wr_en && reg_writable(wr_addr)) begin
			mem[wr_addr[REG_AW-1:0]] <= wr_data;
		end
	end

	// Entry valid bits stand in for the all-zero reset of the array.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en && reg_writable(wr_addr)) begin
			vld_q[wr_addr[REG_AW-1:0]] <= 1'b1;
		end
	end

	// Two registered read ports, each with a flag for a nonzero read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			raw0_q <= mem[rd_addr0[REG_AW-1:0]];
			raw1_q <= mem[rd_addr1[REG_AW-1:0]];
			ok0_q  <= reg_writable(rd_addr0) && vld_q[rd_addr0[REG_AW-1:0]];
			ok1_q  <= reg_writable(rd_addr1) && vld_q[rd_addr1[REG_AW-1:0]];
		end
	end

	assign rd_data0 = ok0_q ? raw0_q : '0;
	assign rd_data1 = ok1_q ? raw1_q : '0;

endmodule

[rtl/svx_pc_table.sv]
module svx_pc_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [svx_pkg::WORKER_W-1:0] rd_addr,
	output logic [svx_pkg::PC_BITS-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [svx_pkg::WORKER_W-1:0] wr_addr,
	input  logic [svx_pkg::PC_BITS-1:0]  wr_data
);
	import svx_pkg::*;

	pc_t                    mem [NUM_WORKERS];
	logic [NUM_WORKERS-1:0] vld_q;
	pc_t                    raw_q;
	logic                   ok_q;

	// Write port for one worker's program counter.
	always_ff @(posedge clk) begin
		if (wr_en && (int'(wr_addr) < NUM_WORKERS)) begin
			mem[wr_addr[WRK_AW-1:0]] <= wr_data;
		end
	end

	// Valid bits give the zero reset value of every counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en && (int'(wr_addr) < NUM_WORKERS)) begin
			vld_q[wr_addr[WRK_AW-1:0]] <= 1'b1;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			raw_q <= mem[rd_addr[WRK_AW-1:0]];
			ok_q  <= (int'(rd_addr) < NUM_WORKERS) && vld_q[rd_addr[WRK_AW-1:0]];
		end
	end

	assign rd_data = ok_q ? raw_q : '0;

endmodule

[rtl/svx_exec.sv]
module svx_exec (
	input  svx_pkg::exe_req_t req,
	output svx_pkg::exe_res_t res
);
	import svx_pkg::*;

	logic  worker_ok;
	logic  links;
	pc_t   link;
	data_t link_val;
	data_t base;
	logic  take;

	assign worker_ok = int'(req.worker) < NUM_WORKERS;
	assign link      = req.pc + pc_t'(1);
	assign link_val  = {{(DATA_W-PC_BITS){1'b0}}, link};

	// JALR whose base is its own link register sees the new link value.
	assign links = reg_writable(req.ra);
	assign base  = (links && (req.ra == req.rb)) ? link_val : req.opnd_a;

	// Branch condition on the two compare operands.
	always_comb begin
		case (op_t'(req.op))
			OP_BEQ:  take = req.opnd_a == req.opnd_b;
			OP_BNE:  take = req.opnd_a != req.opnd_b;
			OP_BLT:  take = $signed(req.opnd_a) < $signed(req.opnd_b);
			OP_BGE:  take = !($signed(req.opnd_a) < $signed(req.opnd_b));
			default: take = 1'b0;
		endcase
	end

	// Opcode decode: next pc, register write and stop.
	always_comb begin
		res.npc   = link;
		res.stop  = 1'b0;
		res.wrote = 1'b0;
		res.wreg  = req.ra;
		res.wval  = '0;
		unique case (op_t'(req.op)) inside
			OP_ADD: begin
				res.wval  = req.opnd_a + req.opnd_b;
				res.wrote = links;
			end
			OP_ADDI: begin
				res.wval  = req.opnd_a + req.imm_c;
				res.wrote = links;
			end
			OP_BEQ, OP_BGE, OP_BLT, OP_BNE: begin
				if (take) begin
					res.npc = pc_t'(req.imm_c);
				end
			end
			OP_JAL: begin
				res.wval  = link_val;
				res.wrote = links;
				res.npc   = pc_t'(req.imm_b) + pc_t'(req.imm_c);
			end
			OP_JALR: begin
				res.wval  = link_val;
				res.wrote = links;
				res.npc   = pc_t'(base + req.imm_c);
			end
			OP_STP: begin
				res.stop = 1'b1;
				res.npc  = req.pc;
			end
			default: begin
				res.npc = link;
			end
		endcase

		// An instruction for a worker that does not exist changes nothing.
		res.pc_we = worker_ok;
		if (!worker_ok) begin
			res.npc   = '0;
			res.stop  = 1'b0;
			res.wrote = 1'b0;
		end
		if (!res.wrote) begin
			res.wreg = '0;
			res.wval = '0;
		end
	end

endmodule

[rtl/schedule_vm_execute_unit.sv]
// The instruction leaving the execute stage writes back and fills the output register.
// Throughput: one instruction per cycle while the output is not stalled; register file
// and pc table are read on acceptance, with a one-entry bypass for each.
// Reset: arst_n clears the pipeline valids and the entry valid bits, so every
// register and pc reads as zero at once; there is no clearing pass.
module schedule_vm_execute_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [svx_pkg::OP_W-1:0]      opcode,
	input  logic [svx_pkg::WORKER_W-1:0]  worker,
	input  logic [svx_pkg::REG_IDX_W-1:0] reg_a,
	input  logic [svx_pkg::REG_IDX_W-1:0] reg_b,
	input  logic [svx_pkg::REG_IDX_W-1:0] reg_c,
	input  logic [svx_pkg::IMM_B_W-1:0]   imm_b,
	input  logic [svx_pkg::DATA_W-1:0]    imm_c,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [svx_pkg::WORKER_W-1:0]  out_worker,
	output logic [svx_pkg::PC_BITS-1:0]   next_pc,
	output logic                          stop,
	output logic                          wrote,
	output logic [svx_pkg::REG_IDX_W-1:0] write_reg,
	output logic [svx_pkg::DATA_W-1:0]    write_value
);
	import svx_pkg::*;

	logic     accept;
	logic     adv_s1;
	logic     is_branch;
	reg_idx_t rd_addr0;
	reg_idx_t rd_addr1;
	data_t    rd_data0;
	data_t    rd_data1;
	pc_t      pc_rdata;
	exe_req_t req;
	exe_res_t res;

	logic            valid_s1;
	logic [OP_W-1:0] op_s1;
	worker_t         worker_s1;
	reg_idx_t        ra_s1;
	reg_idx_t        rb_s1;
	reg_idx_t        addr0_s1;
	reg_idx_t        addr1_s1;
	logic [IMM_B_W-1:0] immb_s1;
	data_t           immc_s1;
	logic            rfw_v_s1;
	reg_idx_t        rfw_reg_s1;
	data_t           rfw_val_s1;
	logic            pcw_v_s1;
	worker_t         pcw_w_s1;
	pc_t             pcw_val_s1;

	logic     valid_s2;
	worker_t  worker_s2;
	pc_t      npc_s2;
	logic     stop_s2;
	logic     wrote_s2;
	reg_idx_t wreg_s2;
	data_t    wval_s2;

	// Handshake: the execute stage moves on whenever the output register frees up.
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	// Branches compare reg_a with reg_b; everything else reads reg_b and reg_c.
	always_comb begin
		unique case (op_t'(opcode)) inside
			OP_BEQ, OP_BGE, OP_BLT, OP_BNE: is_branch = 1'b1;
			default:                        is_branch = 1'b0;
		endcase
	end

	assign rd_addr0 = is_branch ? reg_a : reg_b;
	assign rd_addr1 = is_branch ? reg_b : reg_c;

	svx_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1),
		.wr_en    (adv_s1 && res.wrote),
		.wr_addr  (res.wreg),
		.wr_data  (res.wval)
	);

	svx_pc_table u_pc_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (worker),
		.rd_data (pc_rdata),
		.wr_en   (adv_s1 && res.pc_we),
		.wr_addr (worker_s1),
		.wr_data (res.npc)
	);

	// Execute stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Instruction fields, plus the writes that land on the same edge as the reads.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= opcode;
			worker_s1  <= worker;
			ra_s1      <= reg_a;
			rb_s1      <= reg_b;
			addr0_s1   <= rd_addr0;
			addr1_s1   <= rd_addr1;
			immb_s1    <= imm_b;
			immc_s1    <= imm_c;
			rfw_v_s1   <= adv_s1 && res.wrote;
			rfw_reg_s1 <= res.wreg;
			rfw_val_s1 <= res.wval;
			pcw_v_s1   <= adv_s1 && res.pc_we;
			pcw_w_s1   <= worker_s1;
			pcw_val_s1 <= res.npc;
		end
	end

	// Operand gathering with bypass of the preceding instruction's writes.
	always_comb begin
		req.op     = op_s1;
		req.worker = worker_s1;
		req.ra     = ra_s1;
		req.rb     = rb_s1;
		req.imm_b  = immb_s1;
		req.imm_c  = immc_s1;
		req.opnd_a = (rfw_v_s1 && (rfw_reg_s1 == addr0_s1)) ? rfw_val_s1 : rd_data0;
		req.opnd_b = (rfw_v_s1 && (rfw_reg_s1 == addr1_s1)) ? rfw_val_s1 : rd_data1;
		req.pc     = (pcw_v_s1 && (pcw_w_s1 == worker_s1)) ? pcw_val_s1 : pc_rdata;
	end

	svx_exec u_exec (
		.req (req),
		.res (res)
	);

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			worker_s2 <= worker_s1;
			npc_s2    <= res.npc;
			stop_s2   <= res.stop;
			wrote_s2  <= res.wrote;
			wreg_s2   <= res.wreg;
			wval_s2   <= res.wval;
		end
	end

	assign out_valid   = valid_s2;
	assign out_worker  = worker_s2;
	assign next_pc     = npc_s2;
	assign stop        = stop_s2;
	assign wrote       = wrote_s2;
	assign write_reg   = wreg_s2;
	assign write_value = wval_s2;

`ifndef SYNTHESIS
	a_stall_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled while the pipeline can move");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(op_s1) && $stable(worker_s1)
			&& $stable(rfw_v_s1))
		else $error("stalled execute stage lost its instruction");

	a_stop_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stop |-> !wrote)
		else $error("stop result also reports a register write");

	a_no_zero_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wrote |-> write_reg != '0)
		else $error("write reported to the zero register");

	a_quiet_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !wrote |-> write_reg == '0 && write_value == '0)
		else $error("write fields set without a register write");
`endif

endmodule

[dv/schedule_vm_execute_unit_tb.sv]
module schedule_vm_execute_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import svx_pkg::*;

	// Opcodes with no instruction behind them; they only advance the pc.
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd10;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

	localparam int RANDOM_ITEMS = 1400;
	localparam int MAX_WAIT     = 13;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		worker_t            w;
		reg_idx_t           ra;
		reg_idx_t           rb;
		reg_idx_t           rc;
		logic [IMM_B_W-1:0] ib;
		data_t              ic;
	} instr_t;

	typedef struct packed {
		worker_t  w;
		pc_t      npc;
		logic     stop;
		logic     wrote;
		reg_idx_t wreg;
		data_t    wval;
	} update_t;

	typedef struct packed {
		instr_t  ins;
		logic    known;
		update_t res;
	} dir_row_t;

	localparam update_t NO_RES = '0;
	localparam data_t   S_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam data_t   S_MIN  = 64'h8000_0000_0000_0000;
	localparam data_t   ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

	// Directed instructions. Rows with a typed update are checked against it; the
	// others against the predictor. Pc state runs on from row to row.
	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// Largest positive immediate from the zero register.
		'{'{OP_ADDI, 3'd0, 4'd1, 4'd0, 4'd0, 16'd0, S_MAX}, 1'b1,
			'{3'd0, 16'd1, 1'b0, 1'b1, 4'd1, S_MAX}},
		// Signed overflow wraps to the most negative value.
		'{'{OP_ADDI, 3'd0, 4'd2, 4'd1, 4'd0, 16'd0, 64'd1}, 1'b1,
			'{3'd0, 16'd2, 1'b0, 1'b1, 4'd2, S_MIN}},
		// A write to the zero register is dropped.
		'{'{OP_ADD, 3'd0, 4'd0, 4'd1, 4'd2, 16'd0, 64'd0}, 1'b1,
			'{3'd0, 16'd3, 1'b0, 1'b0, 4'd0, 64'd0}},
		'{'{OP_ADD, 3'd1, 4'd3, 4'd1, 4'd2, 16'd0, 64'd0}, 1'b1,
			'{3'd1, 16'd1, 1'b0, 1'b1, 4'd3, ONES}},
		'{'{OP_ADD, 3'd1, 4'd15, 4'd3, 4'd3, 16'd0, 64'd0}, 1'b0, NO_RES},
		// Signed compare of the extremes; the target is cut to the pc width.
		'{'{OP_BLT, 3'd2, 4'd2, 4'd1, 4'd0, 16'd0, 64'hFFFF_FFFF_FFFF_1234}, 1'b1,
			'{3'd2, 16'h1234, 1'b0, 1'b0, 4'd0, 64'd0}},
		'{'{OP_BGE, 3'd2, 4'd2, 4'd1, 4'd0, 16'd0, 64'd5}, 1'b0, NO_RES},
		'{'{OP_BGE, 3'd3, 4'd1, 4'd1, 4'd0, 16'd0, 64'h0000_0000_0000_FFFF}, 1'b1,
			'{3'd3, 16'hFFFF, 1'b0, 1'b0, 4'd0, 64'd0}},
		// Not taken from the top pc wraps to zero.
		'{'{OP_BNE, 3'd3, 4'd0, 4'd0, 4'd0, 16'd0, 64'd7}, 1'b1,
			'{3'd3, 16'd0, 1'b0, 1'b0, 4'd0, 64'd0}},
		'{'{OP_BEQ, 3'd3, 4'd0, 4'd0, 4'd0, 16'd0, 64'd100}, 1'b0, NO_RES},
		'{'{OP_BNE, 3'd3, 4'd1, 4'd2, 4'd0, 16'd0, S_MIN}, 1'b0, NO_RES},
		'{'{OP_BEQ, 3'd4, 4'd1, 4'd2, 4'd0, 16'd0, 64'd9}, 1'b0, NO_RES},
		// Jump label plus offset wraps at the pc width.
		'{'{OP_JAL, 3'd5, 4'd4, 4'd0, 4'd0, 16'hFFFF, 64'd1}, 1'b1,
			'{3'd5, 16'd0, 1'b0, 1'b1, 4'd4, 64'd1}},
		'{'{OP_JAL, 3'd5, 4'd0, 4'd0, 4'd0, 16'h0010, ONES}, 1'b0, NO_RES},
		// Same link and base register: the base is the fresh link value.
		'{'{OP_JALR, 3'd6, 4'd5, 4'd5, 4'd0, 16'd0, 64'd10}, 1'b1,
			'{3'd6, 16'd11, 1'b0, 1'b1, 4'd5, 64'd1}},
		'{'{OP_JALR, 3'd6, 4'd0, 4'd3, 4'd0, 16'd0, 64'd2}, 1'b0, NO_RES},
		// Stop keeps the pc.
		'{'{OP_STP, 3'd7, 4'd0, 4'd0, 4'd0, 16'd0, 64'd0}, 1'b1,
			'{3'd7, 16'd0, 1'b1, 1'b0, 4'd0, 64'd0}},
		'{'{OP_STP, 3'd5, 4'd15, 4'd15, 4'd15, 16'hFFFF, ONES}, 1'b0, NO_RES},
		'{'{OP_ADV, 3'd7, 4'd0, 4'd0, 4'd0, 16'd0, 64'd0}, 1'b0, NO_RES},
		'{'{OP_UNUSED_HI, 3'd7, 4'd15, 4'd15, 4'd15, 16'hFFFF, ONES}, 1'b0, NO_RES},
		'{'{OP_UNUSED_LO, 3'd4, 4'd1, 4'd2, 4'd3, 16'd0, 64'd0}, 1'b0, NO_RES},
		'{'{OP_ADD, 3'd0, 4'd15, 4'd15, 4'd15, 16'hFFFF, ONES}, 1'b0, NO_RES},
		'{'{OP_BLT, 3'd0, 4'd15, 4'd0, 4'd0, 16'd0, 64'd20}, 1'b0, NO_RES},
		'{'{OP_JALR, 3'd1, 4'd15, 4'd0, 4'd0, 16'd0, ONES}, 1'b0, NO_RES}
	};

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [OP_W-1:0]       opcode      = '0;
	worker_t               worker      = '0;
	reg_idx_t              reg_a       = '0;
	reg_idx_t              reg_b       = '0;
	reg_idx_t              reg_c       = '0;
	logic [IMM_B_W-1:0]    imm_b       = '0;
	data_t                 imm_c       = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	worker_t               out_worker;
	pc_t                   next_pc;
	logic                  stop;
	logic                  wrote;
	reg_idx_t              write_reg;
	data_t                 write_value;

	// Predictor state: shared register file and per-worker program counters.
	data_t   vm_regs [NUM_REGS]    = '{default: '0};
	pc_t     vm_pcs  [NUM_WORKERS] = '{default: '0};
	update_t predicted_results [$];

	int  error_count  = 0;
	int  results_seen = 0;
	bit  source_burst = 1'b0;
	bit  sink_burst   = 1'b0;

	schedule_vm_execute_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.worker      (worker),
		.reg_a       (reg_a),
		.reg_b       (reg_b),
		.reg_c       (reg_c),
		.imm_b       (imm_b),
		.imm_c       (imm_c),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_worker  (out_worker),
		.next_pc     (next_pc),
		.stop        (stop),
		.wrote       (wrote),
		.write_reg   (write_reg),
		.write_value (write_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit well beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic data_t reg_read(input reg_idx_t idx);
		return (idx == '0) ? '0 : vm_regs[idx];
	endfunction

	// Returns 1 when the write really lands in the register file.
	function automatic logic reg_write(input reg_idx_t idx, input data_t value);
		if (idx == '0)
			return 1'b0;
		vm_regs[idx] = value;
		return 1'b1;
	endfunction

	// Executes one instruction on the predictor state and returns its update.
	function automatic update_t execute_instr(input instr_t ins);
		update_t r;
		pc_t     pc;
		pc_t     link;
		data_t   val;
		data_t   base;
		logic    wr;
		r    = '0;
		val  = '0;
		wr   = 1'b0;
		pc   = vm_pcs[ins.w];
		link = pc + pc_t'(1);
		r.w   = ins.w;
		r.npc = link;
		case (ins.op)
			OP_ADD: begin
				val = reg_read(ins.rb) + reg_read(ins.rc);
				wr  = reg_write(ins.ra, val);
			end
			OP_ADDI: begin
				val = reg_read(ins.rb) + ins.ic;
				wr  = reg_write(ins.ra, val);
			end
			OP_BEQ: begin
				if (reg_read(ins.ra) == reg_read(ins.rb))
					r.npc = ins.ic[PC_BITS-1:0];
			end
			OP_BGE: begin
				if (!($signed(reg_read(ins.ra)) < $signed(reg_read(ins.rb))))
					r.npc = ins.ic[PC_BITS-1:0];
			end
			OP_BLT: begin
				if ($signed(reg_read(ins.ra)) < $signed(reg_read(ins.rb)))
					r.npc = ins.ic[PC_BITS-1:0];
			end
			OP_BNE: begin
				if (reg_read(ins.ra) != reg_read(ins.rb))
					r.npc = ins.ic[PC_BITS-1:0];
			end
			OP_JAL: begin
				val   = data_t'(link);
				wr    = reg_write(ins.ra, val);
				r.npc = ins.ib + ins.ic[PC_BITS-1:0];
			end
			OP_JALR: begin
				// The link goes in first, so a shared base register sees it.
				val   = data_t'(link);
				wr    = reg_write(ins.ra, val);
				base  = reg_read(ins.rb);
				r.npc = base[PC_BITS-1:0] + ins.ic[PC_BITS-1:0];
			end
			OP_STP: begin
				r.stop = 1'b1;
				r.npc  = pc;
			end
			default: begin
			end
		endcase
		if (wr) begin
			r.wrote = 1'b1;
			r.wreg  = ins.ra;
			r.wval  = val;
		end
		vm_pcs[ins.w] = r.npc;
		return r;
	endfunction

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Offers one instruction transaction and records its update once accepted.
	task automatic send_instr(input instr_t ins, input logic known, input update_t typed);
		int      gap;
		update_t pred;
		gap = draw_wait(source_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode   <= ins.op;
		worker   <= ins.w;
		reg_a    <= ins.ra;
		reg_b    <= ins.rb;
		reg_c    <= ins.rc;
		imm_b    <= ins.ib;
		imm_c    <= ins.ic;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pred = execute_instr(ins);
		predicted_results.push_back(known ? typed : pred);
	endtask

	// Result side: random stall per transaction, plus long holds to back up the pipe.
	initial begin : result_sink
		int      hold;
		update_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen % 64 == 0)
				sink_burst = ($urandom_range(0, 2) == 0);
			hold = draw_wait(sink_burst);
			if (results_seen == 200 || results_seen == 900)
				hold = LONG_HOLD;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			results_seen++;
			if (predicted_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual worker %0d pc %h",
					$time, out_worker, next_pc);
				error_count++;
			end else begin
				want = predicted_results.pop_front();
				check_field("out_worker", 64'(want.w), 64'(out_worker));
				check_field("next_pc", 64'(want.npc), 64'(next_pc));
				check_field("stop", 64'(want.stop), 64'(stop));
				check_field("wrote", 64'(want.wrote), 64'(wrote));
				check_field("write_reg", 64'(want.wreg), 64'(write_reg));
				check_field("write_value", want.wval, write_value);
			end
		end
	end

	// Reset, directed table, random instructions, then drain.
	initial begin : instr_source
		instr_t ins;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_instr(DIRECTED[i].ins, DIRECTED[i].known, DIRECTED[i].res);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				source_burst = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 15) == 0)
				ins.op = 4'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
			else
				ins.op = 4'($urandom_range(int'(OP_ADD), int'(OP_ADV)));
			ins.w  = 3'($urandom());
			ins.ra = 4'($urandom());
			ins.rb = 4'($urandom());
			ins.rc = 4'($urandom());
			ins.ib = 16'($urandom());
			// Compare a register with itself now and then so equality is hit.
			if (ins.op inside {OP_BEQ, OP_BGE, OP_BLT, OP_BNE} && $urandom_range(0, 3) == 0)
				ins.rb = ins.ra;
			case ($urandom_range(0, 3))
				0: ins.ic = {32'd0, 32'($urandom_range(0, 40))} - 64'd20;
				1: begin
					case ($urandom_range(0, 4))
						0: ins.ic = '0;
						1: ins.ic = 64'd1;
						2: ins.ic = S_MAX;
						3: ins.ic = S_MIN;
						default: ins.ic = ONES;
					endcase
				end
				default: ins.ic = {$urandom(), $urandom()};
			endcase
			send_instr(ins, 1'b0, NO_RES);
		end
		in_valid <= 1'b0;

		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[schedule_vm_execute_unit.f]
rtl/svx_pkg.sv
rtl/svx_regfile.sv
rtl/svx_pc_table.sv
rtl/svx_exec.sv
rtl/schedule_vm_execute_unit.sv
dv/schedule_vm_execute_unit_tb.sv
